>>> hw/rtl/sct_pkg.sv
// Shared types, token codes and word tables for the script character tokenizer.
`default_nettype none

package sct_pkg;

    localparam int MAX_LEXEME_DEF  = 255;
    localparam int HEAD_BYTES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [3:0] KIND_UNKNOWN  = 4'd0;
    localparam logic [3:0] KIND_OPERATOR = 4'd1;
    localparam logic [3:0] KIND_LPAREN   = 4'd2;
    localparam logic [3:0] KIND_RPAREN   = 4'd3;
    localparam logic [3:0] KIND_COMMA    = 4'd4;
    localparam logic [3:0] KIND_LBRACKET = 4'd5;
    localparam logic [3:0] KIND_RBRACKET = 4'd6;
    localparam logic [3:0] KIND_STRING   = 4'd7;
    localparam logic [3:0] KIND_IDENT    = 4'd8;
    localparam logic [3:0] KIND_TYPENAME = 4'd9;
    localparam logic [3:0] KIND_KEYWORD  = 4'd10;
    localparam logic [3:0] KIND_NUMBER   = 4'd11;
    localparam logic [3:0] KIND_END      = 4'd12;

    localparam logic [3:0] OP_DOT     = 4'd8;
    localparam logic [3:0] OP_ASSIGN  = 4'd9;
    localparam logic [3:0] OP_DIVIDE  = 4'd10;
    localparam logic [3:0] OP_MINUS   = 4'd11;
    localparam logic [3:0] OP_PLUS    = 4'd12;
    localparam logic [3:0] OP_TIMES   = 4'd13;
    localparam logic [3:0] OP_PERCENT = 4'd14;

    // Words are packed with the first character in the lowest byte.
    localparam logic [63:0] OPWORD_TEXT [8] = '{
        64'h746c, 64'h65746c, 64'h7467, 64'h657467,
        64'h7369, 64'h746f6e, 64'h646e61, 64'h726f
    };
    localparam logic [7:0] OPWORD_LEN [8] = '{
        8'd2, 8'd3, 8'd2, 8'd3, 8'd2, 8'd3, 8'd3, 8'd2
    };
    localparam logic [63:0] KEYWORD_TEXT [11] = '{
        64'h73696874, 64'h706d63, 64'h706d63646e65, 64'h6f64,
        64'h6e7566, 64'h6e7566646e65, 64'h6669, 64'h6669646e65,
        64'h726f66, 64'h726f66646e65, 64'h6e7275746572
    };
    localparam logic [7:0] KEYWORD_LEN [11] = '{
        8'd4, 8'd3, 8'd6, 8'd2, 8'd3, 8'd6, 8'd2, 8'd5, 8'd3, 8'd6, 8'd6
    };

    typedef struct packed {
        logic [3:0] kind;
        logic [3:0] code;
    } sct_tok_t;

    // One front-end decision: an optional pending lexeme, then an optional
    // single-character or end token.
    typedef struct packed {
        logic        has_flush;
        logic [3:0]  flush_kind;
        logic [7:0]  len;
        logic [63:0] head;
        logic        has_tail;
        logic [3:0]  tail_kind;
        logic [3:0]  tail_code;
        logic [7:0]  tail_char;
    } sct_entry_t;

    function automatic sct_tok_t char_token(input logic [7:0] c);
        sct_tok_t t;
        t.kind = KIND_OPERATOR;
        t.code = 4'd0;
        case (c)
            8'h2e: t.code = OP_DOT;
            8'h3d: t.code = OP_ASSIGN;
            8'h3a: t.code = OP_DIVIDE;
            8'h2f: t.code = OP_DIVIDE;
            8'h2d: t.code = OP_MINUS;
            8'h2b: t.code = OP_PLUS;
            8'h2a: t.code = OP_TIMES;
            8'h25: t.code = OP_PERCENT;
            8'h28: t.kind = KIND_LPAREN;
            8'h29: t.kind = KIND_RPAREN;
            8'h2c: t.kind = KIND_COMMA;
            8'h5b: t.kind = KIND_LBRACKET;
            8'h5d: t.kind = KIND_RBRACKET;
            default: t.kind = KIND_UNKNOWN;
        endcase
        return t;
    endfunction

    // Operator words win, then a capital first letter, then keywords.
    function automatic sct_tok_t classify_word(input logic [7:0] len,
                                               input logic [63:0] head,
                                               input logic saturated);
        sct_tok_t t;
        logic     found;
        t.kind = KIND_IDENT;
        t.code = 4'd0;
        found  = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!found && !saturated && len == OPWORD_LEN[i] && head == OPWORD_TEXT[i]) begin
                found  = 1'b1;
                t.kind = KIND_OPERATOR;
                t.code = 4'(i);
            end
        end
        if (!found && head[7:0] >= 8'h41 && head[7:0] <= 8'h5a) begin
            found  = 1'b1;
            t.kind = KIND_TYPENAME;
        end
        for (int i = 0; i < 11; i++) begin
            if (!found && !saturated && len == KEYWORD_LEN[i] && head == KEYWORD_TEXT[i]) begin
                found  = 1'b1;
                t.kind = KIND_KEYWORD;
                t.code = 4'(i);
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sct_front.sv
// Front end: accepts characters, tracks the lexer mode and decides which tokens follow.
`default_nettype none

module sct_front #(
    parameter int MAX_LEXEME = sct_pkg::MAX_LEXEME_DEF,
    parameter int HEAD_BYTES = sct_pkg::HEAD_BYTES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  wire logic [7:0]         in_char,
    input  wire logic               in_end,
    input  wire logic               q_ready,
    output logic                    q_push,
    output sct_pkg::sct_entry_t     q_entry
);

    localparam int LEN_CAP = (MAX_LEXEME < 255) ? MAX_LEXEME : 255;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_COMMENT = 3'd1;
    localparam logic [2:0] MODE_STR_DQ  = 3'd2;
    localparam logic [2:0] MODE_STR_SQ  = 3'd3;
    localparam logic [2:0] MODE_WORD    = 3'd4;
    localparam logic [2:0] MODE_NUMBER  = 3'd5;

    logic [2:0]          mode_reg, mode_next;
    logic [7:0]          len_reg, len_next;
    logic [63:0]         head_reg, head_next;
    logic [7:0]          app_len;
    logic [63:0]         app_head;
    logic                is_alpha, is_digit, is_space, is_newline, restart, accept;
    sct_pkg::sct_tok_t   tok;
    sct_pkg::sct_entry_t ent;

    assign accept     = in_valid && q_ready;
    assign is_alpha   = (in_char >= 8'h61 && in_char <= 8'h7a) ||
                        (in_char >= 8'h41 && in_char <= 8'h5a);
    assign is_digit   = in_char >= 8'h30 && in_char <= 8'h39;
    assign is_newline = in_char == 8'h0a || in_char == 8'h0d;
    assign is_space   = is_newline || in_char == 8'h20 || in_char == 8'h09;
    assign tok        = sct_pkg::char_token(in_char);

    always_comb begin
        app_head = head_reg;
        for (int i = 0; i < 8; i++) begin
            if (i < HEAD_BYTES && len_reg == 8'(i)) begin
                app_head[8*i +: 8] = in_char;
            end
        end
        app_len = (len_reg < 8'(LEN_CAP)) ? len_reg + 8'd1 : len_reg;
    end

    always_comb begin
        mode_next = mode_reg;
        len_next  = len_reg;
        head_next = head_reg;
        restart   = 1'b0;
        ent       = '0;
        ent.len   = len_reg;
        ent.head  = head_reg;
        case (mode_reg)
            MODE_WORD:   ent.flush_kind = sct_pkg::KIND_IDENT;
            MODE_NUMBER: ent.flush_kind = sct_pkg::KIND_NUMBER;
            default:     ent.flush_kind = sct_pkg::KIND_STRING;
        endcase
        if (in_end) begin
            ent.has_flush = mode_reg == MODE_WORD || mode_reg == MODE_NUMBER ||
                            mode_reg == MODE_STR_DQ || mode_reg == MODE_STR_SQ;
            ent.has_tail  = 1'b1;
            ent.tail_kind = sct_pkg::KIND_END;
            mode_next     = MODE_IDLE;
            len_next      = '0;
            head_next     = '0;
        end else begin
            case (mode_reg)
                MODE_COMMENT: begin
                    if (is_newline) begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_STR_DQ, MODE_STR_SQ: begin
                    if (in_char == ((mode_reg == MODE_STR_DQ) ? 8'h22 : 8'h27)) begin
                        ent.has_flush = 1'b1;
                        mode_next     = MODE_IDLE;
                        len_next      = '0;
                        head_next     = '0;
                    end else begin
                        len_next  = app_len;
                        head_next = app_head;
                    end
                end
                MODE_WORD: begin
                    if (is_alpha || is_digit) begin
                        len_next  = app_len;
                        head_next = app_head;
                    end else begin
                        ent.has_flush = 1'b1;
                        restart       = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit || in_char == 8'h2e) begin
                        len_next  = app_len;
                        head_next = app_head;
                    end else begin
                        ent.has_flush = 1'b1;
                        restart       = 1'b1;
                    end
                end
                default: restart = 1'b1;
            endcase
            // The byte that ended a word or number, or any byte between tokens, starts afresh.
            if (restart) begin
                mode_next = MODE_IDLE;
                len_next  = '0;
                head_next = '0;
                if (is_space) begin
                    mode_next = MODE_IDLE;
                end else if (in_char == 8'h23) begin
                    mode_next = MODE_COMMENT;
                end else if (in_char == 8'h22) begin
                    mode_next = MODE_STR_DQ;
                end else if (in_char == 8'h27) begin
                    mode_next = MODE_STR_SQ;
                end else if (is_alpha || is_digit) begin
                    mode_next = is_alpha ? MODE_WORD : MODE_NUMBER;
                    len_next  = 8'd1;
                    head_next = {56'd0, in_char};
                end else begin
                    ent.has_tail  = 1'b1;
                    ent.tail_kind = tok.kind;
                    ent.tail_code = tok.code;
                    ent.tail_char = in_char;
                end
            end
        end
    end

    assign q_push  = accept && (ent.has_flush || ent.has_tail);
    assign q_entry = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            len_reg  <= '0;
            head_reg <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            head_reg <= head_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sct_queue.sv
// Short register queue of front-end decisions between the front and back ends.
`default_nettype none

module sct_queue #(
    parameter int DEPTH = sct_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire sct_pkg::sct_entry_t push_entry,
    output logic                     push_ready,
    input  wire logic                pop,
    output logic                     pop_valid,
    output sct_pkg::sct_entry_t      pop_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sct_pkg::sct_entry_t slot_reg [DEPTH];
    logic [PW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sct_back.sv
// Back end: classifies words and sends one token per beat from an output register.
`default_nettype none

module sct_back #(
    parameter int MAX_LEXEME = sct_pkg::MAX_LEXEME_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    input  wire sct_pkg::sct_entry_t q_entry,
    output logic                     q_pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [79:0]              m_tdata,
    output logic                     m_tlast
);

    localparam int LEN_CAP = (MAX_LEXEME < 255) ? MAX_LEXEME : 255;

    logic              phase_reg, phase_next;
    logic              tvalid_reg;
    logic [79:0]       tdata_reg, beat_data;
    logic              tlast_reg, beat_last;
    logic              load, take_flush;
    sct_pkg::sct_tok_t word_tok, flush_tok;

    assign word_tok  = sct_pkg::classify_word(q_entry.len, q_entry.head,
                                              q_entry.len >= 8'(LEN_CAP));
    assign flush_tok = (q_entry.flush_kind == sct_pkg::KIND_IDENT) ? word_tok :
                       sct_pkg::sct_tok_t'{kind: q_entry.flush_kind, code: 4'd0};

    // The pending lexeme goes out first; the second phase sends the tail token.
    assign take_flush = !phase_reg && q_entry.has_flush;
    assign load       = q_valid && (!tvalid_reg || m_tready);

    always_comb begin
        phase_next = phase_reg;
        if (take_flush) begin
            beat_data = {q_entry.head, q_entry.len, flush_tok.code, flush_tok.kind};
            beat_last = !q_entry.has_tail;
        end else begin
            beat_data = {56'd0, q_entry.tail_char,
                         (q_entry.tail_kind == sct_pkg::KIND_END) ? 8'd0 : 8'd1,
                         q_entry.tail_code, q_entry.tail_kind};
            beat_last = 1'b1;
        end
        if (load) begin
            phase_next = take_flush && q_entry.has_tail;
        end
    end

    assign q_pop    = load && beat_last;
    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= 1'b0;
            tvalid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (load) begin
                tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tdata_reg <= beat_data;
            tlast_reg <= beat_last;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/script_char_tokenizer_unit.sv
// Top level of the script character tokenizer: front end, decision queue and back end.
//
// Input channel s_*: one source byte per beat in s_tdata[7:0]; s_tuser[0] set marks
// the end of the source, which flushes any pending lexeme and adds an end token.
// Output channel m_*: one token per beat; m_tlast is set on the last token that an
// input beat causes. An input beat gives zero, one or two tokens.
// The front end takes one byte every cycle while the four-entry decision queue has
// room. A byte that completes a token writes it into the decision queue; the output
// register then loads it from there and raises m_tvalid.
// The output register sends one token per cycle while m_tready is high, so sustained
// throughput is one byte per cycle, except that a byte that closes a word or number
// and adds a second token gives two tokens to send; the queue absorbs short bursts of those.
// When the receiver holds m_tready low, the output beat stays put, the queue fills
// and s_tready falls once it is full; nothing is lost.
// Reset returns the lexer to idle between tokens, empties the queue and drops any
// beat in the output register.
`default_nettype none

module script_char_tokenizer_unit #(
    parameter int MAX_LEXEME  = sct_pkg::MAX_LEXEME_DEF,
    parameter int HEAD_BYTES  = sct_pkg::HEAD_BYTES_DEF,
    parameter int QUEUE_DEPTH = sct_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] character
    input  wire logic [0:0]  s_tuser,   // [0] end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [3:0] token_kind, [7:4] word_code,
                                        // [15:8] lexeme_length, [79:16] lexeme_head
    output logic             m_tlast
);

    logic                q_push, q_ready, q_valid, q_pop;
    sct_pkg::sct_entry_t q_in, q_out;

    assign s_tready = q_ready;

    sct_front #(
        .MAX_LEXEME (MAX_LEXEME),
        .HEAD_BYTES (HEAD_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_char  (s_tdata),
        .in_end   (s_tuser[0]),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    sct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_out)
    );

    sct_back #(
        .MAX_LEXEME (MAX_LEXEME)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // The front end only writes a decision when the queue has room for it.
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> q_ready)
        else $error("decision pushed into a full queue");

    // The end token always closes the run of its input beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3:0] == sct_pkg::KIND_END) |-> (m_tlast && m_tdata[15:8] == 8'd0))
        else $error("end token without last flag or with a length");

    // Punctuation tokens are always a single character long.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[3:0] == sct_pkg::KIND_LPAREN ||
                      m_tdata[3:0] == sct_pkg::KIND_RPAREN ||
                      m_tdata[3:0] == sct_pkg::KIND_COMMA ||
                      m_tdata[3:0] == sct_pkg::KIND_LBRACKET ||
                      m_tdata[3:0] == sct_pkg::KIND_RBRACKET)) |-> m_tdata[15:8] == 8'd1)
        else $error("punctuation token with length other than one");
`endif

endmodule

`default_nettype wire

>>> bench/token_checker.sv
`timescale 1ns / 1ps
// Watches both streams of the tokenizer, predicts its tokens and compares them.
module token_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] character
    input  wire logic [0:0]  s_tuser,   // [0] end_of_input
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [79:0] m_tdata,   // [3:0] kind, [7:4] code, [15:8] length, [79:16] head
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending_tokens
);

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] LEN_SAT = 8'd255;

    typedef enum logic [2:0] {
        LEX_IDLE, LEX_COMMENT, LEX_DQ_STRING, LEX_SQ_STRING, LEX_WORD, LEX_NUMBER
    } lex_mode_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  code;
        logic [7:0]  len;
        logic [63:0] head;
        logic        last;
    } token_t;

    token_t      expected_tokens[$];
    lex_mode_t   lex_mode;
    logic [63:0] lexeme_head;
    logic [7:0]  lexeme_len;
    int          tokens_this_beat;
    int          errors;

    function automatic string keyword_text(input int idx);
        case (idx)
            0: return "this";
            1: return "cmp";
            2: return "endcmp";
            3: return "do";
            4: return "fun";
            5: return "endfun";
            6: return "if";
            7: return "endif";
            8: return "for";
            9: return "endfor";
            default: return "return";
        endcase
    endfunction

    function automatic string opword_text(input int idx);
        case (idx)
            0: return "lt";
            1: return "lte";
            2: return "gt";
            3: return "gte";
            4: return "is";
            5: return "not";
            6: return "and";
            default: return "or";
        endcase
    endfunction

    function automatic bit lexeme_is(input string s);
        logic [63:0] packed_text;
        packed_text = '0;
        for (int k = 0; k < s.len(); k++)
            packed_text[8*k +: 8] = s[k];
        return lexeme_len != LEN_SAT && lexeme_len == 8'(s.len()) && lexeme_head == packed_text;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic add_token(input logic [3:0] kind, input logic [3:0] code,
                             input logic [7:0] len, input logic [63:0] head);
        expected_tokens.push_back('{kind, code, len, head, 1'b0});
        tokens_this_beat++;
    endtask

    task automatic grow_lexeme(input logic [7:0] c);
        if (lexeme_len < 8)
            lexeme_head[8*lexeme_len +: 8] = c;
        if (lexeme_len != LEN_SAT)
            lexeme_len++;
    endtask

    // Operator words take priority, then a capital first letter, then keywords.
    task automatic finish_word();
        bit found;
        found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!found && lexeme_is(opword_text(i))) begin
                found = 1'b1;
                add_token(sct_pkg::KIND_OPERATOR, 4'(i), lexeme_len, lexeme_head);
            end
        end
        if (!found && lexeme_head[7:0] >= "A" && lexeme_head[7:0] <= "Z") begin
            found = 1'b1;
            add_token(sct_pkg::KIND_TYPENAME, 4'd0, lexeme_len, lexeme_head);
        end
        for (int i = 0; i < 11; i++) begin
            if (!found && lexeme_is(keyword_text(i))) begin
                found = 1'b1;
                add_token(sct_pkg::KIND_KEYWORD, 4'(i), lexeme_len, lexeme_head);
            end
        end
        if (!found)
            add_token(sct_pkg::KIND_IDENT, 4'd0, lexeme_len, lexeme_head);
    endtask

    task automatic flush_lexeme();
        case (lex_mode)
            LEX_WORD:      finish_word();
            LEX_NUMBER:    add_token(sct_pkg::KIND_NUMBER, 4'd0, lexeme_len, lexeme_head);
            LEX_DQ_STRING,
            LEX_SQ_STRING: add_token(sct_pkg::KIND_STRING, 4'd0, lexeme_len, lexeme_head);
            default: ;
        endcase
        lex_mode    = LEX_IDLE;
        lexeme_head = '0;
        lexeme_len  = '0;
    endtask

    task automatic start_lexeme(input logic [7:0] c);
        lexeme_head = '0;
        lexeme_len  = '0;
        if (c == " " || c == CH_TAB || c == CH_LF || c == CH_CR) begin
        end else if (c == "#") begin
            lex_mode = LEX_COMMENT;
        end else if (c == "\"") begin
            lex_mode = LEX_DQ_STRING;
        end else if (c == "'") begin
            lex_mode = LEX_SQ_STRING;
        end else if (is_letter(c)) begin
            lex_mode = LEX_WORD;
            grow_lexeme(c);
        end else if (is_digit(c)) begin
            lex_mode = LEX_NUMBER;
            grow_lexeme(c);
        end else begin
            case (c)
                ".":      add_token(sct_pkg::KIND_OPERATOR, sct_pkg::OP_DOT, 8'd1, 64'(c));
                "=":      add_token(sct_pkg::KIND_OPERATOR, sct_pkg::OP_ASSIGN, 8'd1, 64'(c));
                ":", "/": add_token(sct_pkg::KIND_OPERATOR, sct_pkg::OP_DIVIDE, 8'd1, 64'(c));
                "-":      add_token(sct_pkg::KIND_OPERATOR, sct_pkg::OP_MINUS, 8'd1, 64'(c));
                "+":      add_token(sct_pkg::KIND_OPERATOR, sct_pkg::OP_PLUS, 8'd1, 64'(c));
                "*":      add_token(sct_pkg::KIND_OPERATOR, sct_pkg::OP_TIMES, 8'd1, 64'(c));
                "%":      add_token(sct_pkg::KIND_OPERATOR, sct_pkg::OP_PERCENT, 8'd1, 64'(c));
                "(":      add_token(sct_pkg::KIND_LPAREN, 4'd0, 8'd1, 64'(c));
                ")":      add_token(sct_pkg::KIND_RPAREN, 4'd0, 8'd1, 64'(c));
                ",":      add_token(sct_pkg::KIND_COMMA, 4'd0, 8'd1, 64'(c));
                "[":      add_token(sct_pkg::KIND_LBRACKET, 4'd0, 8'd1, 64'(c));
                "]":      add_token(sct_pkg::KIND_RBRACKET, 4'd0, 8'd1, 64'(c));
                default:  add_token(sct_pkg::KIND_UNKNOWN, 4'd0, 8'd1, 64'(c));
            endcase
        end
    endtask

    task automatic lex_byte(input logic [7:0] c, input logic end_mark);
        token_t tail;
        tokens_this_beat = 0;
        if (end_mark) begin
            if (lex_mode == LEX_COMMENT)
                lex_mode = LEX_IDLE;
            flush_lexeme();
            add_token(sct_pkg::KIND_END, 4'd0, 8'd0, 64'd0);
        end else begin
            case (lex_mode)
                LEX_COMMENT: begin
                    if (c == CH_LF || c == CH_CR)
                        lex_mode = LEX_IDLE;
                end
                LEX_DQ_STRING, LEX_SQ_STRING: begin
                    if (c == (lex_mode == LEX_DQ_STRING ? 8'("\"") : 8'("'")))
                        flush_lexeme();
                    else
                        grow_lexeme(c);
                end
                LEX_WORD: begin
                    if (is_letter(c) || is_digit(c)) begin
                        grow_lexeme(c);
                    end else begin
                        flush_lexeme();
                        start_lexeme(c);
                    end
                end
                LEX_NUMBER: begin
                    if (is_digit(c) || c == ".") begin
                        grow_lexeme(c);
                    end else begin
                        flush_lexeme();
                        start_lexeme(c);
                    end
                end
                default: start_lexeme(c);
            endcase
        end
        if (tokens_this_beat > 0) begin
            tail = expected_tokens.pop_back();
            tail.last = 1'b1;
            expected_tokens.push_back(tail);
        end
    endtask

    always @(posedge aclk) begin
        token_t got;
        token_t want;
        if (!aresetn) begin
            expected_tokens.delete();
            lex_mode    = LEX_IDLE;
            lexeme_head = '0;
            lexeme_len  = '0;
            errors      = 0;
        end else begin
            // Check the output first: a token leaving now never comes from this input beat.
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[3:0], m_tdata[7:4], m_tdata[15:8], m_tdata[79:16], m_tlast};
                if (expected_tokens.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected token, got kind %0d code %0d len %0d head %h last %b",
                             $time, got.kind, got.code, got.len, got.head, got.last);
                end else begin
                    want = expected_tokens.pop_front();
                    if (got.kind != want.kind || got.code != want.code || got.len != want.len
                        || got.head != want.head || got.last != want.last) begin
                        errors++;
                        $display({"%0t: token mismatch, expected kind %0d code %0d len %0d",
                                  " head %h last %b"},
                                 $time, want.kind, want.code, want.len, want.head, want.last);
                        $display({"%0t:                 got kind %0d code %0d len %0d",
                                  " head %h last %b"},
                                 $time, got.kind, got.code, got.len, got.head, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready)
                lex_byte(s_tdata, s_tuser[0]);
        end
        fail_count     <= errors;
        pending_tokens <= expected_tokens.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Top of the tokenizer bench: clock, reset, source byte stimulus, sink stalls and verdict.
module testbench;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 1450;
    localparam int MAX_WAIT    = 17;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] character
    logic [0:0]  s_tuser;   // [0] end_of_input
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // [3:0] kind, [7:4] code, [15:8] length, [79:16] head
    logic        m_tlast;
    int          fail_count;
    int          pending_tokens;
    int          beats_sent;
    int          cycle_count;
    bit          source_rush;
    bit          sink_rush;

    script_char_tokenizer_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    token_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .pending_tokens (pending_tokens)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Called and returning at a falling edge; holds the beat until it is taken.
    task automatic send_beat(input logic [7:0] c, input logic end_mark);
        int gap;
        if ($urandom_range(0, 49) == 0)
            source_rush = !source_rush;
        gap = source_rush ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= c;
        s_tuser[0] <= end_mark;
        forever begin
            @(posedge aclk);
            if (s_tready)
                break;
        end
        @(negedge aclk);
        beats_sent++;
    endtask

    task automatic send_char(input logic [7:0] c);
        send_beat(c, 1'b0);
    endtask

    function automatic logic [7:0] random_letter();
        int r;
        r = $urandom_range(0, 51);
        return r < 26 ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] random_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10)
            return 8'("0" + r);
        return random_letter();
    endfunction

    // One well-formed lexeme with random content, or a piece of noise.
    task automatic send_random_lexeme();
        string       punct;
        logic [63:0] text;
        logic [7:0]  quote;
        logic [7:0]  b;
        int          pick;
        int          n;
        int          idx;
        punct = ".=:/-+*%()[],";
        pick  = $urandom_range(0, 99);
        if (pick < 20) begin
            idx = $urandom_range(0, 18);
            text = idx < 11 ? sct_pkg::KEYWORD_TEXT[idx] : sct_pkg::OPWORD_TEXT[idx - 11];
            n    = idx < 11 ? sct_pkg::KEYWORD_LEN[idx] : sct_pkg::OPWORD_LEN[idx - 11];
            if ($urandom_range(0, 7) == 0)
                text[5] = 1'b0;  // capital first letter makes a typename
            for (int k = 0; k < n; k++)
                send_char(text[8*k +: 8]);
            if ($urandom_range(0, 9) == 0)
                send_char(random_alnum());
        end else if (pick < 35) begin
            n = ($urandom_range(0, 149) == 0) ? $urandom_range(250, 270) : $urandom_range(0, 9);
            send_char(random_letter());
            for (int k = 0; k < n; k++)
                send_char(random_alnum());
        end else if (pick < 45) begin
            send_char(8'("0" + $urandom_range(0, 9)));
            n = $urandom_range(0, 8);
            for (int k = 0; k < n; k++)
                send_char($urandom_range(0, 4) == 0 ? 8'(".") : 8'("0" + $urandom_range(0, 9)));
        end else if (pick < 55) begin
            quote = $urandom_range(0, 1) ? 8'("\"") : 8'("'");
            send_char(quote);
            n = $urandom_range(0, 10);
            for (int k = 0; k < n; k++) begin
                b = 8'($urandom_range(0, 255));
                send_char(b == quote ? b ^ 8'h01 : b);
            end
            if ($urandom_range(0, 9) != 0)
                send_char(quote);
        end else if (pick < 63) begin
            send_char("#");
            n = $urandom_range(0, 10);
            for (int k = 0; k < n; k++) begin
                b = 8'($urandom_range(0, 255));
                send_char(b == 8'h0a || b == 8'h0d ? 8'("x") : b);
            end
            if ($urandom_range(0, 7) != 0)
                send_char($urandom_range(0, 1) ? 8'h0a : 8'h0d);
        end else if (pick < 80) begin
            send_char(punct[$urandom_range(0, punct.len() - 1)]);
        end else if (pick < 90) begin
            case ($urandom_range(0, 3))
                0: send_char(" ");
                1: send_char(8'h09);
                2: send_char(8'h0a);
                default: send_char(8'h0d);
            endcase
        end else if (pick < 97) begin
            send_char(8'($urandom_range(0, 255)));
        end else begin
            send_beat(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // The sink draws a stall before each token it takes.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 49) == 0)
                sink_rush = !sink_rush;
            stall = sink_rush ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            forever begin
                @(posedge aclk);
                if (m_tvalid)
                    break;
            end
            @(negedge aclk);
        end
    end

    initial begin
        string opening;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        beats_sent  = 0;
        cycle_count = 0;
        source_rush = 1'b0;
        sink_rush   = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // A keyword cut by a paren, a typename, a quoted string, a number cut by an
        // operator, a comment to a line end, then a non-ASCII and a NUL byte.
        opening = "endcmp(Ty,'s')=12.5%#x\n";
        for (int k = 0; k < opening.len(); k++)
            send_char(opening[k]);
        send_char(8'hff);
        send_char(8'h00);
        send_beat(8'hff, 1'b1);

        while (beats_sent < ITEM_TARGET)
            send_random_lexeme();
        send_beat(8'h00, 1'b1);
        s_tvalid <= 1'b0;

        while (pending_tokens != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
